>>> src/ascii_video_stream_parser_defines.svh
// Assertion macros shared by the parser RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef ASCII_VIDEO_STREAM_PARSER_DEFINES_SVH
`define ASCII_VIDEO_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define AVSP_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while in reset.
`define AVSP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

>>> src/avsp_pkg.sv
// Shared types and constants of the ASCII-video stream parser.
// No dependencies; avsp_regs, avsp_parser, the top level and the testbench import it.
`default_nettype none

package avsp_pkg;

  // Result kinds
  localparam logic [4:0] KIND_VERSION      = 5'd0;
  localparam logic [4:0] KIND_WIDTH        = 5'd1;
  localparam logic [4:0] KIND_HEIGHT       = 5'd2;
  localparam logic [4:0] KIND_FPS          = 5'd3;
  localparam logic [4:0] KIND_FRAME_COUNT  = 5'd4;
  localparam logic [4:0] KIND_HAS_AUDIO    = 5'd5;
  localparam logic [4:0] KIND_CHARSET_SIZE = 5'd6;
  localparam logic [4:0] KIND_CHARSET_ENT  = 5'd7;
  localparam logic [4:0] KIND_FRAME_START  = 5'd8;
  localparam logic [4:0] KIND_I_PIXEL      = 5'd9;
  localparam logic [4:0] KIND_P_COUNT      = 5'd10;
  localparam logic [4:0] KIND_P_ENTRY      = 5'd11;
  localparam logic [4:0] KIND_AUDIO_FMT    = 5'd12;
  localparam logic [4:0] KIND_AUDIO_LEN    = 5'd13;
  localparam logic [4:0] KIND_AUDIO_BYTE   = 5'd14;
  localparam logic [4:0] KIND_END          = 5'd15;
  localparam logic [4:0] KIND_ERROR        = 5'd16;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_FILE_SIG    = 3'd1;
  localparam logic [2:0] ERR_VERSION     = 3'd2;
  localparam logic [2:0] ERR_CHARSET_SIG = 3'd3;
  localparam logic [2:0] ERR_FRAMES_SIG  = 3'd4;
  localparam logic [2:0] ERR_FRAME_TYPE  = 3'd5;
  localparam logic [2:0] ERR_AUDIO_SIG   = 3'd6;

  // Section signatures, little-endian words
  localparam logic [31:0] SIG_FILE    = 32'h0656_5341;
  localparam logic [31:0] SIG_CHARSET = 32'h1a00_336e;
  localparam logic [31:0] SIG_FRAMES  = 32'h0901_1d1e;
  localparam logic [31:0] SIG_AUDIO   = 32'h1214_ff7f;

  // Frame type bytes
  localparam logic [7:0] FTYPE_I = 8'd0;
  localparam logic [7:0] FTYPE_P = 8'd1;

  // Register file
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_VERSION = '0;
  localparam logic [15:0] MAX_VERSION_RESET = 16'd100;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } avsp_in_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] value;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] frame_number;
    logic [2:0]  error_code;
  } avsp_out_t;

endpackage

`default_nettype wire

>>> src/avsp_stream_if.sv
// Valid/ready stream channel with a typed payload.
// The payload type is set by the instantiating level (avsp_pkg structs).
`default_nettype none

interface avsp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/avsp_regs.sv
// APB-style configuration registers of the stream parser.
// Depends on avsp_pkg.
`default_nettype none

module avsp_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [avsp_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output logic      [15:0]                     max_version
);
  import avsp_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_version <= MAX_VERSION_RESET;
    end else if (wr_en && reg_idx == REG_MAX_VERSION) begin
      max_version <= pwdata[15:0];
    end
  end

  always_comb begin
    if (reg_idx == REG_MAX_VERSION) begin
      prdata = {16'd0, max_version};
    end else begin
      prdata = '0;
    end
  end

endmodule

`default_nettype wire

>>> src/avsp_parser.sv
// Byte-at-a-time container parser: input register, parse state, result register.
// Depends on avsp_pkg, avsp_stream_if and the assertion macro header.
`default_nettype none
`include "ascii_video_stream_parser_defines.svh"

module avsp_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] max_version,
  avsp_stream_if.sink      in_stream,
  avsp_stream_if.source    out_stream
);
  import avsp_pkg::*;

  typedef enum logic [4:0] {
    PH_FSIG, PH_VER, PH_WID, PH_HEI, PH_FPS, PH_FCNT, PH_HAUD, PH_CSIG,
    PH_CSIZE, PH_CENT, PH_VSIG, PH_FTYPE, PH_IPIX, PH_PCNT, PH_PCHAR, PH_PX,
    PH_PY, PH_ASIG, PH_AFMT, PH_ALEN, PH_ABYTE, PH_DONE, PH_FIN, PH_ERR
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  byte_in_field;
    logic [31:0] assembly;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] frames_total;
    logic [31:0] frames_done;
    logic        audio_present;
    logic [31:0] items_left;
    logic [15:0] col_counter;
    logic [15:0] row_counter;
    logic [7:0]  entry_char;
    logic [15:0] entry_x;
  } parse_state_t;

  localparam parse_state_t ST_RESET = '{
    phase: PH_FSIG, byte_in_field: 2'd0, assembly: 32'd0,
    frame_width: 16'd0, frame_height: 16'd0, frames_total: 32'd0,
    frames_done: 32'd0, audio_present: 1'b0, items_left: 32'd0,
    col_counter: 16'd0, row_counter: 16'd0, entry_char: 8'd0, entry_x: 16'd0
  };

  // Registers
  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_restart;
  parse_state_t st;
  logic         out_valid;
  avsp_out_t    out_data;

  // Step logic
  parse_state_t cur;
  parse_state_t st_next;
  avsp_out_t    res;
  logic         emit;
  logic         s1_adv;
  logic         is_take;
  logic         take4;
  logic         fdone;
  logic [31:0]  acc;
  logic [31:0]  pix_count;
  logic         pix_zero;
  logic [31:0]  fd_inc;
  logic [31:0]  left_dec;
  logic [15:0]  col_inc;
  phase_t       after_phase;
  phase_t       ff_phase;
  logic         st_byte_phase;

  assign s1_adv          = s1_valid && (!out_valid || out_stream.ready);
  assign in_stream.ready = !s1_valid || s1_adv;
  assign out_stream.valid   = out_valid;
  assign out_stream.payload = out_data;

  assign cur       = s1_restart ? ST_RESET : st;
  assign acc       = cur.assembly | ({24'd0, s1_byte} << {cur.byte_in_field, 3'b000});
  assign pix_count = {16'd0, cur.frame_width} * {16'd0, cur.frame_height};
  assign pix_zero  = (cur.frame_width == 16'd0) || (cur.frame_height == 16'd0);
  assign fd_inc    = cur.frames_done + 32'd1;
  assign left_dec  = cur.items_left - 32'd1;
  assign col_inc   = cur.col_counter + 16'd1;
  assign after_phase = cur.audio_present ? PH_ASIG : PH_DONE;
  assign ff_phase    = (fd_inc == cur.frames_total) ? after_phase : PH_FTYPE;
  assign fdone       = take4 ? (cur.byte_in_field == 2'd3) : (cur.byte_in_field != 2'd0);

  // Single-byte phases, never entered mid-field
  assign st_byte_phase = st.phase inside {PH_CENT, PH_IPIX, PH_PCHAR, PH_ABYTE, PH_HAUD};

  // Field length of the multi-byte phases
  always_comb begin
    is_take = 1'b1;
    take4   = 1'b0;
    case (cur.phase)
      PH_FSIG, PH_FPS, PH_FCNT, PH_CSIG, PH_VSIG, PH_PCNT, PH_ASIG, PH_ALEN: begin
        take4 = 1'b1;
      end
      PH_VER, PH_WID, PH_HEI, PH_PX, PH_PY: begin
        take4 = 1'b0;
      end
      default: begin
        is_take = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_next = cur;
    emit    = 1'b0;
    res     = '0;

    if (is_take) begin
      if (fdone) begin
        st_next.assembly      = '0;
        st_next.byte_in_field = '0;
      end else begin
        st_next.assembly      = acc;
        st_next.byte_in_field = cur.byte_in_field + 2'd1;
      end
    end

    case (cur.phase)
      PH_FSIG: begin
        if (fdone) begin
          if (acc != SIG_FILE) begin
            st_next.phase = PH_ERR;
            emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_FILE_SIG;
          end else begin
            st_next.phase = PH_VER;
          end
        end
      end
      PH_VER: begin
        if (fdone) begin
          emit = 1'b1;
          if (acc > {16'd0, max_version}) begin
            st_next.phase = PH_ERR;
            res.kind = KIND_ERROR; res.error_code = ERR_VERSION;
          end else begin
            st_next.phase = PH_WID;
            res.kind = KIND_VERSION; res.value = acc;
          end
        end
      end
      PH_WID: begin
        if (fdone) begin
          st_next.frame_width = acc[15:0];
          st_next.phase = PH_HEI;
          emit = 1'b1; res.kind = KIND_WIDTH; res.value = acc;
        end
      end
      PH_HEI: begin
        if (fdone) begin
          st_next.frame_height = acc[15:0];
          st_next.phase = PH_FPS;
          emit = 1'b1; res.kind = KIND_HEIGHT; res.value = acc;
        end
      end
      PH_FPS: begin
        if (fdone) begin
          st_next.phase = PH_FCNT;
          emit = 1'b1; res.kind = KIND_FPS; res.value = acc;
        end
      end
      PH_FCNT: begin
        if (fdone) begin
          st_next.frames_total = acc;
          st_next.phase = PH_HAUD;
          emit = 1'b1; res.kind = KIND_FRAME_COUNT; res.value = acc;
        end
      end
      PH_HAUD: begin
        st_next.audio_present = (s1_byte != 8'd0);
        st_next.phase = PH_CSIG;
        emit = 1'b1; res.kind = KIND_HAS_AUDIO;
        res.value = {31'd0, (s1_byte != 8'd0)};
      end
      PH_CSIG: begin
        if (fdone) begin
          if (acc != SIG_CHARSET) begin
            st_next.phase = PH_ERR;
            emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_CHARSET_SIG;
          end else begin
            st_next.phase = PH_CSIZE;
          end
        end
      end
      PH_CSIZE: begin
        st_next.items_left  = {24'd0, s1_byte};
        st_next.col_counter = '0;
        st_next.phase = (s1_byte == 8'd0) ? PH_VSIG : PH_CENT;
        emit = 1'b1; res.kind = KIND_CHARSET_SIZE; res.value = {24'd0, s1_byte};
      end
      PH_CENT: begin
        st_next.col_counter = col_inc;
        st_next.items_left  = left_dec;
        if (left_dec == 32'd0) begin
          st_next.phase = PH_VSIG;
        end
        emit = 1'b1; res.kind = KIND_CHARSET_ENT; res.value = {24'd0, s1_byte};
        res.pos_x = cur.col_counter;
      end
      PH_VSIG: begin
        if (fdone) begin
          if (acc != SIG_FRAMES) begin
            st_next.phase = PH_ERR;
            emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_FRAMES_SIG;
          end else begin
            st_next.frames_done = '0;
            st_next.phase = (cur.frames_total == 32'd0) ? after_phase : PH_FTYPE;
          end
        end
      end
      PH_FTYPE: begin
        emit = 1'b1;
        if (s1_byte == FTYPE_I) begin
          st_next.items_left  = pix_count;
          st_next.col_counter = '0;
          st_next.row_counter = '0;
          if (pix_zero) begin
            st_next.frames_done = fd_inc;
            st_next.phase = ff_phase;
          end else begin
            st_next.phase = PH_IPIX;
          end
          res.kind = KIND_FRAME_START; res.value = {24'd0, s1_byte};
          res.frame_number = cur.frames_done;
        end else if (s1_byte == FTYPE_P) begin
          st_next.phase = PH_PCNT;
          res.kind = KIND_FRAME_START; res.value = {24'd0, s1_byte};
          res.frame_number = cur.frames_done;
        end else begin
          st_next.phase = PH_ERR;
          res.kind = KIND_ERROR; res.error_code = ERR_FRAME_TYPE;
        end
      end
      PH_IPIX: begin
        if (col_inc >= cur.frame_width) begin
          st_next.col_counter = '0;
          st_next.row_counter = cur.row_counter + 16'd1;
        end else begin
          st_next.col_counter = col_inc;
        end
        st_next.items_left = left_dec;
        if (left_dec == 32'd0) begin
          st_next.frames_done = fd_inc;
          st_next.phase = ff_phase;
        end
        emit = 1'b1; res.kind = KIND_I_PIXEL; res.value = {24'd0, s1_byte};
        res.pos_x = cur.col_counter; res.pos_y = cur.row_counter;
        res.frame_number = cur.frames_done;
      end
      PH_PCNT: begin
        if (fdone) begin
          st_next.items_left = acc;
          if (acc == 32'd0) begin
            st_next.frames_done = fd_inc;
            st_next.phase = ff_phase;
          end else begin
            st_next.phase = PH_PCHAR;
          end
          emit = 1'b1; res.kind = KIND_P_COUNT; res.value = acc;
          res.frame_number = cur.frames_done;
        end
      end
      PH_PCHAR: begin
        st_next.entry_char = s1_byte;
        st_next.phase = PH_PX;
      end
      PH_PX: begin
        if (fdone) begin
          st_next.entry_x = acc[15:0];
          st_next.phase = PH_PY;
        end
      end
      PH_PY: begin
        if (fdone) begin
          st_next.items_left = left_dec;
          if (left_dec == 32'd0) begin
            st_next.frames_done = fd_inc;
            st_next.phase = ff_phase;
          end else begin
            st_next.phase = PH_PCHAR;
          end
          emit = 1'b1; res.kind = KIND_P_ENTRY; res.value = {24'd0, cur.entry_char};
          res.pos_x = cur.entry_x; res.pos_y = acc[15:0];
          res.frame_number = cur.frames_done;
        end
      end
      PH_ASIG: begin
        if (fdone) begin
          if (acc != SIG_AUDIO) begin
            st_next.phase = PH_ERR;
            emit = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_AUDIO_SIG;
          end else begin
            st_next.phase = PH_AFMT;
          end
        end
      end
      PH_AFMT: begin
        st_next.phase = PH_ALEN;
        emit = 1'b1; res.kind = KIND_AUDIO_FMT; res.value = {24'd0, s1_byte};
      end
      PH_ALEN: begin
        if (fdone) begin
          st_next.items_left = acc;
          st_next.phase = (acc == 32'd0) ? PH_DONE : PH_ABYTE;
          emit = 1'b1; res.kind = KIND_AUDIO_LEN; res.value = acc;
        end
      end
      PH_ABYTE: begin
        st_next.items_left = left_dec;
        if (left_dec == 32'd0) begin
          st_next.phase = PH_DONE;
        end
        emit = 1'b1; res.kind = KIND_AUDIO_BYTE; res.value = {24'd0, s1_byte};
      end
      PH_DONE: begin
        st_next.phase = PH_FIN;
        emit = 1'b1; res.kind = KIND_END;
      end
      default: begin
        // finished or failed: swallow bytes until restart
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      st        <= ST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (in_stream.valid && in_stream.ready) begin
        s1_valid   <= 1'b1;
        s1_byte    <= in_stream.payload.data_byte;
        s1_restart <= in_stream.payload.restart;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        st <= st_next;
        out_valid <= emit;
        if (emit) begin
          out_data <= res;
        end
      end else if (out_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `AVSP_ASSERT_NEXT(a_err_sticks, s1_adv && emit && res.kind == KIND_ERROR, st.phase == PH_ERR)
  `AVSP_ASSERT_NOW(a_err_silent, s1_adv && !s1_restart && st.phase == PH_ERR, !emit)
  `AVSP_ASSERT_NOW(a_fin_silent, s1_adv && !s1_restart && st.phase == PH_FIN, !emit)
  `AVSP_ASSERT_NOW(a_byte_phase_aligned, st_byte_phase, st.byte_in_field == 2'd0)
  `AVSP_ASSERT_NEXT(a_stall_holds_state, s1_valid && !s1_adv, $stable(st) && s1_valid)

endmodule

`default_nettype wire

>>> src/ascii_video_stream_parser.sv
// Top level of the ASCII-video container stream parser (uses avsp_pkg,
// avsp_stream_if, avsp_regs and avsp_parser).
// A byte request is accepted into the input register; its result request leaves from the result register.
// Throughput: one byte per cycle while the result side is ready, set by the parse step.
// Reset (rst, synchronous): parse restarts at the file signature, max_version = 100.
`default_nettype none

module ascii_video_stream_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [avsp_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  // byte requests in (payload avsp_in_t), result requests out (avsp_out_t)
  avsp_stream_if.sink                          in_stream,
  avsp_stream_if.source                        out_stream
);
  import avsp_pkg::*;

  // Version limit; the user must write it only while the parser is idle, which the block does not enforce.
  logic [15:0] max_version;

  avsp_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_version (max_version)
  );

  // Parser: an input register holds one byte request, the parse step
  // updates all counters and the field assembly, and the result
  // register lets a new byte enter while a result waits.
  // A byte that completes no field, or a correct signature, gives no result.
  // Errors park the parse until a byte with restart set arrives.
  avsp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .max_version (max_version),
    .in_stream   (in_stream),
    .out_stream  (out_stream)
  );

endmodule

`default_nettype wire

>>> verif/ascii_video_stream_parser_test.sv
// Self-checking testbench for the ASCII-video stream parser: random container files,
// broken files and byte noise, with a byte-level parse predictor and APB register checks.
// Depends on avsp_pkg, avsp_stream_if and the ascii_video_stream_parser RTL.
module ascii_video_stream_parser_test;
  import avsp_pkg::*;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 10;     // slack once all queues are empty
  localparam int PHASE_BYTES    = 250;    // random bytes per register setting

  // Parse phases, in container order
  typedef enum logic [4:0] {
    S_FILE_SIG, S_VERSION, S_WIDTH, S_HEIGHT, S_FPS, S_FRAME_CNT, S_HAS_AUDIO,
    S_CSET_SIG, S_CSET_SIZE, S_CSET_ENT, S_FRAMES_SIG, S_FRAME_TYPE, S_I_PIXEL,
    S_P_COUNT, S_P_CHAR, S_P_X, S_P_Y, S_AUDIO_SIG, S_AUDIO_FMT, S_AUDIO_LEN,
    S_AUDIO_BYTE, S_DONE, S_FINISHED, S_FAILED
  } parse_phase_e;

  // How a generated file is damaged
  typedef enum int {FLAW_NONE, FLAW_SIG, FLAW_VERSION, FLAW_FTYPE, FLAW_HUGE} flaw_e;
  typedef enum int {SEC_FILE, SEC_CHARSET, SEC_FRAMES, SEC_AUDIO} section_e;
  typedef enum int {HUGE_FRAMES, HUGE_PCOUNT, HUGE_AUDIO} huge_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  avsp_stream_if #(.payload_t(avsp_in_t))  byte_if ();
  avsp_stream_if #(.payload_t(avsp_out_t)) result_if ();

  ascii_video_stream_parser dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_stream  (byte_if),
    .out_stream (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Byte requests waiting to be driven, result requests still to arrive
  avsp_in_t    pending_bytes[$];
  avsp_out_t   expected_results[$];
  logic [7:0]  file_bytes[$];      // scratch buffer for one generated file
  int          stim_count;
  int          fault_count;

  // Idle control, percent chance per cycle that a gap starts
  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned send_gap;
  int unsigned hold_gap;
  logic        byte_taken;         // byte request accepted at the last rising edge

  // ---------------------------------------------------------------------------
  // Parse predictor state (own copy of register and parse state)
  // ---------------------------------------------------------------------------
  logic [15:0]  cfg_max_version;
  parse_phase_e parse_phase;
  logic [1:0]   field_pos;
  logic [31:0]  field_acc;
  logic [15:0]  frame_w, frame_h;
  logic [31:0]  frame_total, frame_index;
  logic         audio_on;
  logic [31:0]  remaining;
  logic [15:0]  col, row;
  logic [7:0]   ent_char;
  logic [15:0]  ent_x;

  task automatic clear_parse();
    parse_phase = S_FILE_SIG;
    field_pos   = '0;
    field_acc   = '0;
    frame_w     = '0;
    frame_h     = '0;
    frame_total = '0;
    frame_index = '0;
    audio_on    = 1'b0;
    remaining   = '0;
    col         = '0;
    row         = '0;
    ent_char    = '0;
    ent_x       = '0;
  endtask

  // Little-endian field assembly; returns 1 with the value on the last byte
  function automatic bit take_field(input int n, input logic [7:0] b,
                                    output logic [31:0] v);
    logic [31:0] acc;
    acc = field_acc | (32'(b) << (8 * field_pos));
    v = acc;
    if (int'(field_pos) + 1 >= n) begin
      field_acc = '0;
      field_pos = '0;
      return 1'b1;
    end
    field_acc = acc;
    field_pos = field_pos + 2'd1;
    return 1'b0;
  endfunction

  task automatic emit(input logic [4:0] kind, input logic [31:0] value,
                      input logic [15:0] x, input logic [15:0] y,
                      input logic [31:0] fn, input logic [2:0] err);
    avsp_out_t r;
    r.kind         = kind;
    r.value        = value;
    r.pos_x        = x;
    r.pos_y        = y;
    r.frame_number = fn;
    r.error_code   = err;
    expected_results.insert(expected_results.size(), r);
  endtask

  // An error item replaces anything else; parse is dead until restart
  task automatic raise(input logic [2:0] err);
    parse_phase = S_FAILED;
    emit(KIND_ERROR, '0, '0, '0, '0, err);
  endtask

  task automatic leave_frames();
    parse_phase = audio_on ? S_AUDIO_SIG : S_DONE;
  endtask

  task automatic close_frame();
    frame_index = frame_index + 1;
    if (frame_index == frame_total) leave_frames();
    else parse_phase = S_FRAME_TYPE;
  endtask

  task automatic predict_byte(input avsp_in_t req);
    logic [7:0]  b;
    logic [31:0] v;
    logic [31:0] fn;
    logic [15:0] px, py;
    b = req.data_byte;
    if (req.restart) clear_parse();
    fn = frame_index;
    case (parse_phase)
      S_FILE_SIG: if (take_field(4, b, v)) begin
        if (v != SIG_FILE) raise(ERR_FILE_SIG);
        else parse_phase = S_VERSION;
      end
      S_VERSION: if (take_field(2, b, v)) begin
        if (v > {16'h0, cfg_max_version}) raise(ERR_VERSION);
        else begin
          parse_phase = S_WIDTH;
          emit(KIND_VERSION, v, '0, '0, '0, ERR_NONE);
        end
      end
      S_WIDTH: if (take_field(2, b, v)) begin
        frame_w = v[15:0];
        parse_phase = S_HEIGHT;
        emit(KIND_WIDTH, v, '0, '0, '0, ERR_NONE);
      end
      S_HEIGHT: if (take_field(2, b, v)) begin
        frame_h = v[15:0];
        parse_phase = S_FPS;
        emit(KIND_HEIGHT, v, '0, '0, '0, ERR_NONE);
      end
      S_FPS: if (take_field(4, b, v)) begin
        parse_phase = S_FRAME_CNT;
        emit(KIND_FPS, v, '0, '0, '0, ERR_NONE);
      end
      S_FRAME_CNT: if (take_field(4, b, v)) begin
        frame_total = v;
        parse_phase = S_HAS_AUDIO;
        emit(KIND_FRAME_COUNT, v, '0, '0, '0, ERR_NONE);
      end
      S_HAS_AUDIO: begin
        audio_on = (b != 8'h00);
        parse_phase = S_CSET_SIG;
        emit(KIND_HAS_AUDIO, 32'(audio_on), '0, '0, '0, ERR_NONE);
      end
      S_CSET_SIG: if (take_field(4, b, v)) begin
        if (v != SIG_CHARSET) raise(ERR_CHARSET_SIG);
        else parse_phase = S_CSET_SIZE;
      end
      S_CSET_SIZE: begin
        remaining = 32'(b);
        col = '0;
        parse_phase = (b == 8'h00) ? S_FRAMES_SIG : S_CSET_ENT;
        emit(KIND_CHARSET_SIZE, 32'(b), '0, '0, '0, ERR_NONE);
      end
      S_CSET_ENT: begin
        px = col;
        col = col + 16'd1;
        remaining = remaining - 1;
        if (remaining == 0) parse_phase = S_FRAMES_SIG;
        emit(KIND_CHARSET_ENT, 32'(b), px, '0, '0, ERR_NONE);
      end
      S_FRAMES_SIG: if (take_field(4, b, v)) begin
        if (v != SIG_FRAMES) raise(ERR_FRAMES_SIG);
        else begin
          frame_index = '0;
          if (frame_total == 0) leave_frames();
          else parse_phase = S_FRAME_TYPE;
        end
      end
      S_FRAME_TYPE: begin
        if (b == FTYPE_I) begin
          remaining = 32'(frame_w) * 32'(frame_h);
          col = '0;
          row = '0;
          if (remaining == 0) close_frame();
          else parse_phase = S_I_PIXEL;
          emit(KIND_FRAME_START, 32'(b), '0, '0, fn, ERR_NONE);
        end else if (b == FTYPE_P) begin
          parse_phase = S_P_COUNT;
          emit(KIND_FRAME_START, 32'(b), '0, '0, fn, ERR_NONE);
        end else begin
          raise(ERR_FRAME_TYPE);
        end
      end
      S_I_PIXEL: begin
        px = col;
        py = row;
        col = col + 16'd1;
        if (col >= frame_w) begin
          col = '0;
          row = row + 16'd1;
        end
        remaining = remaining - 1;
        if (remaining == 0) close_frame();
        emit(KIND_I_PIXEL, 32'(b), px, py, fn, ERR_NONE);
      end
      S_P_COUNT: if (take_field(4, b, v)) begin
        remaining = v;
        if (v == 0) close_frame();
        else parse_phase = S_P_CHAR;
        emit(KIND_P_COUNT, v, '0, '0, fn, ERR_NONE);
      end
      S_P_CHAR: begin
        ent_char = b;
        parse_phase = S_P_X;
      end
      S_P_X: if (take_field(2, b, v)) begin
        ent_x = v[15:0];
        parse_phase = S_P_Y;
      end
      S_P_Y: if (take_field(2, b, v)) begin
        remaining = remaining - 1;
        if (remaining == 0) close_frame();
        else parse_phase = S_P_CHAR;
        emit(KIND_P_ENTRY, 32'(ent_char), ent_x, v[15:0], fn, ERR_NONE);
      end
      S_AUDIO_SIG: if (take_field(4, b, v)) begin
        if (v != SIG_AUDIO) raise(ERR_AUDIO_SIG);
        else parse_phase = S_AUDIO_FMT;
      end
      S_AUDIO_FMT: begin
        parse_phase = S_AUDIO_LEN;
        emit(KIND_AUDIO_FMT, 32'(b), '0, '0, '0, ERR_NONE);
      end
      S_AUDIO_LEN: if (take_field(4, b, v)) begin
        remaining = v;
        parse_phase = (v == 0) ? S_DONE : S_AUDIO_BYTE;
        emit(KIND_AUDIO_LEN, v, '0, '0, '0, ERR_NONE);
      end
      S_AUDIO_BYTE: begin
        remaining = remaining - 1;
        if (remaining == 0) parse_phase = S_DONE;
        emit(KIND_AUDIO_BYTE, 32'(b), '0, '0, '0, ERR_NONE);
      end
      S_DONE: begin
        // any byte after the last field closes the parse
        parse_phase = S_FINISHED;
        emit(KIND_END, '0, '0, '0, '0, ERR_NONE);
      end
      default: ;  // finished or failed: silent until restart
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: results checked against the oldest expectation, then the
  // byte accepted at this edge (if any) goes through the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_taken <= !rst && byte_if.valid && byte_if.ready;
    if (rst) begin
      clear_parse();
      cfg_max_version = MAX_VERSION_RESET;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result request: kind=%0d value=%h err=%0d",
                     result_if.payload.kind, result_if.payload.value,
                     result_if.payload.error_code);
        end else begin
          avsp_out_t exp_r;
          exp_r = expected_results.pop_front();
          if (result_if.payload !== exp_r) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("mismatch exp: kind=%0d value=%h x=%0d y=%0d frame=%0d err=%0d",
                       exp_r.kind, exp_r.value, exp_r.pos_x, exp_r.pos_y,
                       exp_r.frame_number, exp_r.error_code);
              $display("         got: kind=%0d value=%h x=%0d y=%0d frame=%0d err=%0d",
                       result_if.payload.kind, result_if.payload.value,
                       result_if.payload.pos_x, result_if.payload.pos_y,
                       result_if.payload.frame_number, result_if.payload.error_code);
            end
          end
        end
      end
      if (byte_if.valid && byte_if.ready) predict_byte(byte_if.payload);
      // register port: track writes, check read data
      if (psel && penable && pready) begin
        if (pwrite && paddr == {REG_MAX_VERSION, 2'b00}) begin
          cfg_max_version = pwdata[15:0];
        end else if (!pwrite && prdata !== {16'h0, cfg_max_version}) begin
          fault_count++;
          if (fault_count <= 10)
            $display("max_version read: exp %h got %h", {16'h0, cfg_max_version}, prdata);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: holds each byte request until accepted, with random idle bursts
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (!byte_if.valid || byte_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          byte_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0 && $urandom_range(99) < send_idle_pct) begin
          send_gap <= $urandom_range(13, 1) - 1;
          byte_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          byte_if.payload <= pending_bytes.pop_front();
          byte_if.valid <= 1'b1;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: ready drops for random bursts
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_gap > 0) begin
        hold_gap <= hold_gap - 1;
        result_if.ready <= 1'b0;
      end else if ($urandom_range(99) < recv_idle_pct) begin
        hold_gap <= $urandom_range(13, 1) - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic rs);
    avsp_in_t req;
    req.data_byte = b;
    req.restart   = rs;
    pending_bytes.insert(pending_bytes.size(), req);
    stim_count++;
  endtask

  // Append one byte to the file buffer
  task automatic put_file_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic add_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) put_file_byte(v[8*i +: 8]);
  endtask

  // Signature word, optionally with one bit flipped
  task automatic add_sig(input logic [31:0] sig, input bit bad);
    add_le(bad ? sig ^ (32'h1 << $urandom_range(31)) : sig, 4);
  endtask

  // Queue the first keep bytes of the buffer; the first one restarts the parse
  task automatic send_file(input int keep);
    for (int i = 0; i < keep; i++) push_byte(file_bytes[i], i == 0);
    file_bytes.delete();
  endtask

  // One container file into file_bytes. Counts are kept small; a huge count
  // ends the file early, so the next file's restart cuts it off.
  task automatic build_file(input flaw_e flaw);
    section_e    bad_sec;
    huge_e       huge_part;
    logic [15:0] mv, w, h;
    logic [31:0] ver, nframes, cnt, alen;
    logic [7:0]  ftype;
    int          sz, audio, bad_frame;
    longint      npix;
    mv        = cfg_max_version;
    bad_sec   = section_e'($urandom_range(3));
    huge_part = huge_e'($urandom_range(2));
    audio     = $urandom_range(1);
    if ((flaw == FLAW_SIG && bad_sec == SEC_AUDIO) ||
        (flaw == FLAW_HUGE && huge_part == HUGE_AUDIO)) audio = 1;

    add_sig(SIG_FILE, flaw == FLAW_SIG && bad_sec == SEC_FILE);
    if (flaw == FLAW_VERSION && mv != 16'hFFFF) begin
      ver = $urandom_range(65535, int'(mv) + 1);
    end else begin
      case ($urandom_range(2))
        0:       ver = 0;
        1:       ver = 32'(mv);
        default: ver = $urandom_range(mv, 0);
      endcase
    end
    add_le(ver, 2);

    // mostly tiny frames; sometimes one dimension zero, rarely both huge
    case ($urandom_range(9))
      0: begin
        w = '0;
        h = 16'($urandom());
      end
      1: begin
        w = 16'($urandom());
        h = '0;
      end
      2: begin
        w = 16'($urandom_range(65535, 256));
        h = 16'($urandom_range(65535, 256));
      end
      default: begin
        w = 16'($urandom_range(4, 1));
        h = 16'($urandom_range(3, 1));
      end
    endcase
    add_le(32'(w), 2);
    add_le(32'(h), 2);
    add_le($urandom(), 4);  // fps bits

    if (flaw == FLAW_HUGE && huge_part == HUGE_FRAMES) nframes = $urandom();
    else if (flaw == FLAW_FTYPE) nframes = $urandom_range(3, 1);
    else nframes = $urandom_range(3, 0);
    add_le(nframes, 4);
    put_file_byte(audio ? 8'($urandom_range(255, 1)) : 8'h00);

    add_sig(SIG_CHARSET, flaw == FLAW_SIG && bad_sec == SEC_CHARSET);
    sz = ($urandom_range(24) == 0) ? 255 : $urandom_range(5, 0);
    put_file_byte(8'(sz));
    repeat (sz) put_file_byte(8'($urandom()));

    add_sig(SIG_FRAMES, flaw == FLAW_SIG && bad_sec == SEC_FRAMES);
    bad_frame = (flaw == FLAW_FTYPE) ? $urandom_range(nframes - 1, 0) : -1;
    npix = longint'(w) * longint'(h);
    for (int f = 0; f < nframes && f < 3; f++) begin
      if (f == bad_frame) begin
        put_file_byte(8'($urandom_range(255, 2)));
        return;
      end
      ftype = $urandom_range(1) ? FTYPE_P : FTYPE_I;
      put_file_byte(ftype);
      if (ftype == FTYPE_I) begin
        if (npix > 12) begin
          repeat ($urandom_range(6, 1)) put_file_byte(8'($urandom()));
          return;
        end
        repeat (int'(npix)) put_file_byte(8'($urandom()));
      end else begin
        if (flaw == FLAW_HUGE && huge_part == HUGE_PCOUNT) cnt = $urandom();
        else cnt = $urandom_range(3, 0);
        add_le(cnt, 4);
        // entry: char byte, then x and y as one random word
        repeat ((cnt > 3) ? 2 : int'(cnt)) begin
          put_file_byte(8'($urandom()));
          add_le($urandom(), 4);
        end
        if (cnt > 3) return;
      end
    end
    if (nframes > 3) return;

    if (audio) begin
      add_sig(SIG_AUDIO, flaw == FLAW_SIG && bad_sec == SEC_AUDIO);
      put_file_byte(8'($urandom()));
      if (flaw == FLAW_HUGE && huge_part == HUGE_AUDIO) alen = $urandom();
      else alen = $urandom_range(6, 0);
      add_le(alen, 4);
      repeat ((alen > 6) ? 3 : int'(alen)) put_file_byte(8'($urandom()));
      if (alen > 6) return;
    end
    put_file_byte(8'($urandom()));                             // closes the parse
    repeat ($urandom_range(2)) put_file_byte(8'($urandom()));  // ignored tail
  endtask

  // APB transfer, setup then access
  task automatic apb_access(input logic wr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_MAX_VERSION, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block is idle: nothing queued, nothing in flight, then latency slack
  task automatic drain();
    while (pending_bytes.size() != 0 || byte_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: five register settings, each followed by random files
  // ---------------------------------------------------------------------------
  initial begin
    int   r;
    flaw_e flaw;
    logic [15:0] mv;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    byte_if.valid   = 1'b0;
    byte_if.payload = '0;
    result_if.ready = 1'b0;
    send_gap        = 0;
    hold_gap        = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    stim_count      = 0;
    fault_count     = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      // setting 0 runs on the reset value; then both extremes, random, back to default
      if (p > 0) begin
        case (p)
          1:       mv = 16'h0000;
          2:       mv = 16'hFFFF;
          3:       mv = 16'($urandom());
          default: mv = MAX_VERSION_RESET;
        endcase
        apb_access(1'b1, {16'($urandom()), mv});  // upper bits are not stored
        apb_access(1'b0, '0);
      end
      // idle mix per setting; last one runs with no idling at all
      case (p)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 20;
        end
        1: begin
          send_idle_pct = 0;
          recv_idle_pct = 30;
        end
        2: begin
          send_idle_pct = 30;
          recv_idle_pct = 0;
        end
        3: begin
          send_idle_pct = 40;
          recv_idle_pct = 40;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (p == 0) begin
        // bad file signature in the top byte, then a byte the dead parse ignores
        add_le(SIG_FILE ^ 32'hFF00_0000, 4);
        send_file(4);
        push_byte(8'hFF, 1'b0);
        // good signature, version far above the reset limit
        add_le(SIG_FILE, 4);
        add_le(32'h0000_FFFF, 2);
        send_file(6);
        // restart on a zero byte mid-noise
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
      end

      while (stim_count < (p + 1) * PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 65) begin
          build_file(FLAW_NONE);
          send_file(file_bytes.size());
        end else if (r < 82) begin
          flaw = flaw_e'($urandom_range(4, 1));
          build_file(flaw);
          send_file(file_bytes.size());
        end else if (r < 92) begin
          // well-formed file cut short; the next restart takes over
          build_file(FLAW_NONE);
          send_file($urandom_range(file_bytes.size() - 1, 1));
        end else begin
          repeat ($urandom_range(6, 1)) push_byte(8'($urandom()), $urandom_range(3) == 0);
        end
      end
      drain();
    end

    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

endmodule
